>>> rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the star wildcard matcher
// Sizes of the pattern cell row, the command codes and the control struct
// that the top level broadcasts along the row of cells.
// ----------------------------------------------------------------------------
package swm_pkg;

	// Pattern bytes kept; further bytes of a pattern are dropped.
	localparam int MAX_PATTERN = 64;
	// One cell per stored literal plus the head cell (state zero).
	localparam int NCELL = MAX_PATTERN + 1;
	// Width of a count that runs from zero up to MAX_PATTERN.
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	localparam logic [7:0] STAR_BYTE = 8'h2A;

	typedef enum logic [1:0] {
		CMD_PAT_BYTE  = 2'd0,
		CMD_PAT_END   = 2'd1,
		CMD_SUBJ_BYTE = 2'd2,
		CMD_SUBJ_END  = 2'd3
	} cmd_t;

	// Control broadcast to every cell in the same cycle.
	typedef struct packed {
		logic       advance;    // step the state bits on a subject byte
		logic       restart;    // load the start state
		logic       from_start; // current state is the start state
		logic [7:0] subj_byte;  // subject byte compared in every cell
	} swm_cell_ctrl_t;

endpackage

>>> rtl/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell: one state of the collapsed wildcard automaton
// Holds one pattern literal, a flag for a star run after it, and the active
// bit of the state reached after that literal.
// ----------------------------------------------------------------------------
module swm_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head,
	input  swm_pkg::swm_cell_ctrl_t ctrl,
	input  logic                    wr_lit,
	input  logic                    wr_star,
	input  logic                    clr_star,
	input  logic [7:0]              lit_byte,
	input  logic                    prev_act,
	output logic                    act
);

	logic [7:0] lit_q;
	logic       star_q;
	logic       act_q;
	logic       lit_hit;

	// The state bit as seen this cycle; the start state has only the head set.
	assign act     = ctrl.from_start ? head : act_q;
	assign lit_hit = prev_act && (lit_q == ctrl.subj_byte);

	always_ff @(posedge clk) begin
		if (wr_lit) begin
			lit_q <= lit_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			star_q <= 1'b0;
		end else if (wr_lit) begin
			star_q <= 1'b0;
		end else if (wr_star) begin
			star_q <= 1'b1;
		end else if (clr_star) begin
			star_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= head;
		end else if (ctrl.restart) begin
			act_q <= head;
		end else if (ctrl.advance) begin
			// Enter on a literal match, or stay while a star run follows.
			act_q <= lit_hit || (act && star_q);
		end
	end

endmodule

>>> rtl/star_wildcard_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_wildcard_matcher: glob matcher where '*' matches any run of bytes
// Result: registered, shown in the cycle after the subject-end beat.
// Throughput: one input beat per cycle, every command, save a subject-end beat
// held by a full, stalled output; one row update per beat sets the rate.
// Reset: empty pattern, no overflow, not loading, only the head state active.
// The stored literal bytes hold no reset value and need no clearing pass.
// ----------------------------------------------------------------------------
module star_wildcard_matcher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       pattern_overflow
);

	// The pattern is kept in collapsed form: each literal gets a cell, and a
	// run of stars becomes a self-loop flag on the cell before it. Cell zero is
	// the head state with no literal. On a subject byte, a cell becomes active
	// if its left neighbor was active and its literal equals the byte, or if it
	// was active itself and carries a star flag. No epsilon closure is needed,
	// so every cell only looks at its left neighbor.

	swm_pkg::cmd_t cmd_in;

	logic [swm_pkg::LEN_W-1:0] raw_len_q;  // raw pattern bytes kept
	logic [swm_pkg::LEN_W-1:0] lit_cnt_q;  // literal cells in use
	logic                      loading_q;
	logic                      ovf_q;

	logic                      out_valid_q;
	logic                      matched_q;
	logic                      ovf_out_q;

	logic                      accept;
	logic                      new_pat;
	logic                      empty_pat;
	logic                      room;
	logic                      is_star;
	logic                      lit_we;
	logic                      star_we;
	logic                      res_fire;
	logic [swm_pkg::LEN_W-1:0] len_base;
	logic [swm_pkg::LEN_W-1:0] cnt_base;
	logic [swm_pkg::LEN_W-1:0] lit_idx;
	logic [swm_pkg::LEN_W-1:0] raw_len_d;
	logic [swm_pkg::LEN_W-1:0] lit_cnt_d;
	logic                      loading_d;
	logic                      ovf_d;

	swm_pkg::swm_cell_ctrl_t   cell_ctrl;
	logic [swm_pkg::NCELL-1:0] act_vec;

	assign cmd_in = swm_pkg::cmd_t'(cmd);

	// Only a subject-end beat makes a result, so only it waits on a full
	// output register.
	assign in_stall = out_valid_q && out_stall && (cmd_in == swm_pkg::CMD_SUBJ_END);
	assign accept   = in_valid && !in_stall;

	// Pattern loading. A pattern byte outside a pattern starts a new one, and
	// a pattern end outside a pattern loads the empty pattern.
	assign new_pat   = accept && (cmd_in == swm_pkg::CMD_PAT_BYTE) && !loading_q;
	assign empty_pat = accept && (cmd_in == swm_pkg::CMD_PAT_END) && !loading_q;
	assign len_base  = new_pat ? '0 : raw_len_q;
	assign cnt_base  = new_pat ? '0 : lit_cnt_q;
	assign room      = len_base < swm_pkg::LEN_W'(swm_pkg::MAX_PATTERN);
	assign is_star   = data_byte == swm_pkg::STAR_BYTE;
	assign lit_idx   = cnt_base + swm_pkg::LEN_W'(1);
	assign lit_we    = accept && (cmd_in == swm_pkg::CMD_PAT_BYTE) && room && !is_star;
	assign star_we   = accept && (cmd_in == swm_pkg::CMD_PAT_BYTE) && room && is_star;
	assign res_fire  = accept && (cmd_in == swm_pkg::CMD_SUBJ_END);

	always_comb begin
		raw_len_d = raw_len_q;
		lit_cnt_d = lit_cnt_q;
		loading_d = loading_q;
		ovf_d     = ovf_q;
		if (accept) begin
			unique case (cmd_in)
				swm_pkg::CMD_PAT_BYTE: begin
					loading_d = 1'b1;
					if (room) begin
						raw_len_d = len_base + swm_pkg::LEN_W'(1);
						lit_cnt_d = is_star ? cnt_base : lit_idx;
						ovf_d     = new_pat ? 1'b0 : ovf_q;
					end else begin
						ovf_d = 1'b1;
					end
				end
				swm_pkg::CMD_PAT_END: begin
					loading_d = 1'b0;
					if (!loading_q) begin
						raw_len_d = '0;
						lit_cnt_d = '0;
						ovf_d     = 1'b0;
					end
				end
				swm_pkg::CMD_SUBJ_BYTE,
				swm_pkg::CMD_SUBJ_END: begin
					loading_d = 1'b0;
				end
				default: begin
					loading_d = loading_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_len_q <= '0;
			lit_cnt_q <= '0;
			loading_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			raw_len_q <= raw_len_d;
			lit_cnt_q <= lit_cnt_d;
			loading_q <= loading_d;
			ovf_q     <= ovf_d;
		end
	end

	// Broadcast to the row. While a pattern is still open, a subject beat
	// first closes it, so the cells see the start state in place of their
	// stored bits.
	always_comb begin
		cell_ctrl.advance    = accept && (cmd_in == swm_pkg::CMD_SUBJ_BYTE);
		cell_ctrl.restart    = accept && ((cmd_in == swm_pkg::CMD_PAT_END) ||
		                                  (cmd_in == swm_pkg::CMD_SUBJ_END));
		cell_ctrl.from_start = loading_q;
		cell_ctrl.subj_byte  = data_byte;
	end

	for (genvar i = 0; i < swm_pkg::NCELL; i++) begin : g_cell
		logic prev_act;
		logic wr_lit;
		logic wr_star;

		if (i == 0) begin : g_head
			assign prev_act = 1'b0;
		end else begin : g_body
			assign prev_act = act_vec[i-1];
		end

		assign wr_lit  = lit_we && (lit_idx == swm_pkg::LEN_W'(i));
		assign wr_star = star_we && (cnt_base == swm_pkg::LEN_W'(i));

		swm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.head     (i == 0),
			.ctrl     (cell_ctrl),
			.wr_lit   (wr_lit),
			.wr_star  (wr_star),
			.clr_star ((i == 0) && (new_pat || empty_pat)),
			.lit_byte (data_byte),
			.prev_act (prev_act),
			.act      (act_vec[i])
		);
	end

	// Result register. The whole subject matched when the state after the
	// last literal is active.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			matched_q <= act_vec[lit_cnt_q];
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = ovf_out_q;

	// The literal count never runs past the raw byte count.
	a_cnt_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		lit_cnt_q <= raw_len_q)
		else $error("literal count exceeds pattern length");

	// The raw byte count stays within the store.
	a_len_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		raw_len_q <= swm_pkg::LEN_W'(swm_pkg::MAX_PATTERN))
		else $error("pattern length exceeds store");

	// A subject-end beat always shows up as a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> out_valid_q)
		else $error("result beat missing after subject end");

	// A subject beat always closes an open pattern.
	a_subject_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((cmd_in == swm_pkg::CMD_SUBJ_BYTE) ||
		            (cmd_in == swm_pkg::CMD_SUBJ_END))) |=> !loading_q)
		else $error("pattern left open after subject beat");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the star wildcard matcher
// Loads patterns and streams subjects through the valid/stall input port while
// the result port is stalled at random. Each subject-end beat produces one
// expected verdict, and every result beat is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_X = 8'h78;
	localparam int RANDOM_BEATS = 520;
	localparam int POS_W = swm_pkg::MAX_PATTERN + 2;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	// One line of the directed table. A row can repeat its beat, which keeps
	// long patterns to a single line. Rows flagged as typed carry the verdict
	// that their last beat must produce.
	typedef struct packed {
		swm_pkg::cmd_t cmd;
		logic [7:0]    data;
		logic [7:0]    reps;
		logic          typed;
		verdict_t      want;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] cmd = swm_pkg::CMD_PAT_BYTE;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       matched;
	logic       pattern_overflow;

	star_wildcard_matcher u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.data_byte        (data_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor state: the bench's own copy of the pattern, its length, the
	// set of live pattern positions and the loading and overflow flags.
	// ------------------------------------------------------------------------
	logic [7:0]       glob_mem [swm_pkg::MAX_PATTERN];
	int               glob_len = 0;
	logic [POS_W-1:0] live_pos = 1;
	bit               loading = 1'b0;
	bit               overflow_seen = 1'b0;

	verdict_t pending_verdicts[$];
	int       error_count = 0;
	int       beats_sent = 0;
	bit       calm = 1'b0;
	int       stall_left = 0;

	// The start set holds position zero and every position reachable from it
	// through leading stars, since a star may match the empty run.
	function automatic logic [POS_W-1:0] start_positions();
		logic [POS_W-1:0] v;
		int k;
		v = '0;
		v[0] = 1'b1;
		k = 0;
		while (k < glob_len && glob_mem[k] == swm_pkg::STAR_BYTE) begin
			k++;
			v[k] = 1'b1;
		end
		return v;
	endfunction

	// One subject byte moves every live position. A live star stays live and
	// also opens the next position; a literal that equals the byte opens the
	// next position and every star run right after it.
	function automatic logic [POS_W-1:0] step_positions(input logic [7:0] c);
		logic [POS_W-1:0] nxt;
		int k;
		nxt = '0;
		for (int j = 0; j < glob_len; j++) begin
			if (live_pos[j]) begin
				if (glob_mem[j] == swm_pkg::STAR_BYTE) begin
					nxt[j] = 1'b1;
					nxt[j+1] = 1'b1;
				end else if (glob_mem[j] == c) begin
					k = j + 1;
					nxt[k] = 1'b1;
					while (k < glob_len && glob_mem[k] == swm_pkg::STAR_BYTE) begin
						k++;
						nxt[k] = 1'b1;
					end
				end
			end
		end
		return nxt;
	endfunction

	// Applies one accepted beat to the predictor. A subject end is the only
	// command that yields a verdict.
	task automatic predict_beat(input swm_pkg::cmd_t c, input logic [7:0] d,
			output bit gives, output verdict_t v);
		gives = 1'b0;
		v = '0;
		case (c)
			swm_pkg::CMD_PAT_BYTE: begin
				// The first pattern byte after a close starts a fresh pattern.
				if (!loading) begin
					loading = 1'b1;
					glob_len = 0;
					overflow_seen = 1'b0;
				end
				if (glob_len < swm_pkg::MAX_PATTERN) begin
					glob_mem[glob_len] = d;
					glob_len++;
				end else begin
					overflow_seen = 1'b1;
				end
			end
			swm_pkg::CMD_PAT_END: begin
				// A pattern end with nothing loaded selects the empty pattern.
				if (!loading) begin
					glob_len = 0;
					overflow_seen = 1'b0;
				end
				loading = 1'b0;
				live_pos = start_positions();
			end
			swm_pkg::CMD_SUBJ_BYTE: begin
				if (loading) begin
					loading = 1'b0;
					live_pos = start_positions();
				end
				live_pos = step_positions(d);
			end
			default: begin
				if (loading) begin
					loading = 1'b0;
					live_pos = start_positions();
				end
				gives = 1'b1;
				v.matched = live_pos[glob_len];
				v.overflow = overflow_seen;
				live_pos = start_positions();
			end
		endcase
	endtask

	// Idle lengths: mostly none or short, now and then a long one, and none at
	// all while the bench is in a calm stretch.
	function automatic int pick_idle();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Bytes lean toward a small alphabet and the star so that random patterns
	// and subjects actually meet, with the extreme byte values mixed in.
	function automatic logic [7:0] glob_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return CH_A;
		if (r == 3)
			return CH_B;
		if (r < 6)
			return swm_pkg::STAR_BYTE;
		if (r == 6)
			return 8'h00;
		if (r == 7)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic row_t row(input swm_pkg::cmd_t c, input logic [7:0] d,
			input int n, input bit t, input logic m, input logic o);
		row_t x;
		x.cmd = c;
		x.data = d;
		x.reps = 8'(n);
		x.typed = t;
		x.want.matched = m;
		x.want.overflow = o;
		return x;
	endfunction

	// Presents one input beat, holds it until the block takes it, then feeds
	// the predictor. A typed verdict replaces the predicted one in the queue,
	// while the predictor still advances its state.
	task automatic send_beat(input swm_pkg::cmd_t c, input logic [7:0] d,
			input bit typed, input verdict_t want);
		int gap;
		bit gives;
		verdict_t v;
		gap = pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		data_byte <= d;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		predict_beat(c, d, gives, v);
		if (gives)
			pending_verdicts.push_back(typed ? want : v);
	endtask

	// Calm stretches: for a while neither side idles at all.
	initial begin
		forever begin
			repeat ($urandom_range(50, 300)) @(posedge clk);
			calm <= ~calm;
		end
	end

	// Result side stall pattern.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_idle();
		end
	end

	// Every result beat is matched against the oldest outstanding verdict.
	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("result beat with no verdict outstanding: matched %0b, overflow %0b",
					matched, pattern_overflow);
				error_count++;
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (matched !== exp_v.matched) begin
					$error("matched: expected %0b, actual %0b", exp_v.matched, matched);
					error_count++;
				end
				if (pattern_overflow !== exp_v.overflow) begin
					$error("pattern_overflow: expected %0b, actual %0b",
						exp_v.overflow, pattern_overflow);
					error_count++;
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		row_t       rows[$];
		logic [7:0] pat[$];
		logic [7:0] subj[$];
		logic [7:0] b;
		int         plen;
		int         first_beat;

		// Directed table. Typed verdicts are the ones that follow directly from
		// the definition; the rest are left to the predictor.
		// Empty pattern after reset against the empty subject, then against
		// a one-byte subject.
		rows.push_back(row(swm_pkg::CMD_SUBJ_END, 8'h00, 1, 1, 1'b1, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_BYTE, CH_A, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_END, 8'h00, 1, 1, 1'b0, 1'b0));
		// Pattern "a*b" left open; the first subject byte closes it. The star
		// swallows a zero byte.
		rows.push_back(row(swm_pkg::CMD_PAT_BYTE, CH_A, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_PAT_BYTE, swm_pkg::STAR_BYTE, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_PAT_BYTE, CH_B, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_BYTE, CH_A, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_BYTE, 8'h00, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_BYTE, CH_B, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_END, 8'h00, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_END, 8'hFF, 1, 0, 1'b0, 1'b0));
		// Literal zero and all-ones bytes in pattern and subject.
		rows.push_back(row(swm_pkg::CMD_PAT_BYTE, 8'h00, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_PAT_BYTE, 8'hFF, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_PAT_END, 8'h55, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_BYTE, 8'h00, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_BYTE, 8'hFF, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_END, 8'h00, 1, 0, 1'b0, 1'b0));
		// Too many stars: the store fills, the flag sets, and the subject end
		// that closes the pattern sees a match on the empty subject.
		rows.push_back(row(swm_pkg::CMD_PAT_BYTE, swm_pkg::STAR_BYTE, 70, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_END, 8'h00, 1, 1, 1'b1, 1'b1));
		// A bare pattern end loads the empty pattern and clears the flag; a
		// star in the subject is an ordinary byte.
		rows.push_back(row(swm_pkg::CMD_PAT_END, 8'h00, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_BYTE, swm_pkg::STAR_BYTE, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_END, 8'h00, 1, 1, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_PAT_END, 8'hFF, 1, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_END, 8'hAA, 1, 1, 1'b1, 1'b0));
		// A pattern that exactly fills the store does not overflow.
		rows.push_back(row(swm_pkg::CMD_PAT_BYTE, CH_X, swm_pkg::MAX_PATTERN, 0, 1'b0, 1'b0));
		rows.push_back(row(swm_pkg::CMD_SUBJ_END, 8'h00, 1, 1, 1'b0, 1'b0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			for (int r = 0; r < rows[i].reps; r++)
				send_beat(rows[i].cmd, rows[i].data,
					rows[i].typed && (r == rows[i].reps - 1), rows[i].want);
		end

		// Random part: mostly a pattern followed by a few subjects, many of
		// them built to match it, with some noise beats in between.
		first_beat = beats_sent;
		while (beats_sent - first_beat < RANDOM_BEATS) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 5))
					send_beat(swm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom),
						1'b0, '0);
			end

			plen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 72)
				: $urandom_range(0, 8);
			pat.delete();
			for (int k = 0; k < plen; k++) begin
				b = glob_byte();
				send_beat(swm_pkg::CMD_PAT_BYTE, b, 1'b0, '0);
				if (pat.size() < swm_pkg::MAX_PATTERN)
					pat.push_back(b);
			end
			// Sometimes the subject itself closes the pattern.
			if (plen == 0 || $urandom_range(0, 2) != 0)
				send_beat(swm_pkg::CMD_PAT_END, 8'($urandom), 1'b0, '0);

			repeat ($urandom_range(1, 4)) begin
				subj.delete();
				if ($urandom_range(0, 3) != 0) begin
					foreach (pat[k]) begin
						if (pat[k] == swm_pkg::STAR_BYTE) begin
							repeat ($urandom_range(0, 3))
								subj.push_back(glob_byte());
						end else begin
							subj.push_back(pat[k]);
						end
					end
					// Occasionally spoil one byte so near misses show up too.
					if ($urandom_range(0, 3) == 0 && subj.size() > 0)
						subj[$urandom_range(0, subj.size() - 1)] = glob_byte();
				end else if ($urandom_range(0, 19) == 0) begin
					repeat ($urandom_range(100, 300))
						subj.push_back(glob_byte());
				end else begin
					repeat ($urandom_range(0, 6))
						subj.push_back(glob_byte());
				end
				foreach (subj[k])
					send_beat(swm_pkg::CMD_SUBJ_BYTE, subj[k], 1'b0, '0);
				send_beat(swm_pkg::CMD_SUBJ_END, 8'($urandom), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
